// ===== rtl/prat_pkg.sv =====
`timescale 1ns / 1ps
package prat_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned PidW = 22;

  localparam logic [1:0] ReqInsert    = 2'd0;
  localparam logic [1:0] ReqRemove    = 2'd1;
  localparam logic [1:0] ReqTranslate = 2'd2;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatMiss = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  typedef enum logic [1:0] {
    OpInsert,
    OpRemove,
    OpTranslate,
    OpBad
  } op_e;

  // one region as stored in the table
  typedef struct packed {
    logic [PidW-1:0] pid;
    logic [63:0]     start;
    logic [63:0]     stop;
    logic [63:0]     page_offset;
    logic [63:0]     inode;
    logic [31:0]     major;
    logic [31:0]     minor;
    logic [63:0]     generation;
  } region_t;

  // classified request handed from front to back
  typedef struct packed {
    op_e             op;
    logic [PidW-1:0] pid;
    logic [63:0]     address;
    region_t         region;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] file_offset;
    logic [63:0] inode;
    logic [31:0] major;
    logic [31:0] minor;
    logic [63:0] generation;
  } rsp_t;

endpackage

// ===== rtl/process_region_address_translator.sv =====
`timescale 1ns / 1ps
// Region table translating (process, address) into file offset and identity.
// Insert and unknown requests pass from acceptance through the done state to
// the result register; remove and translate walk the table one stored region
// at a time (registered memory read then compare). A two-entry queue lets new
// transactions be accepted while one is processed; one result register holds
// the answer, and the next transaction starts only once it is taken.
module process_region_address_translator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [21:0] proc_id_i,
  input  logic [63:0] address_i,
  input  logic [63:0] length_i,
  input  logic [63:0] page_offset_i,
  input  logic [63:0] inode_i,
  input  logic [31:0] dev_major_i,
  input  logic [31:0] dev_minor_i,
  input  logic [63:0] inode_generation_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [63:0] file_offset_o,
  output logic [63:0] hit_inode_o,
  output logic [31:0] hit_major_o,
  output logic [31:0] hit_minor_o,
  output logic [63:0] hit_generation_o
);

  prat_pkg::cmd_t cmd;
  prat_pkg::rsp_t rsp;
  logic           cmd_valid, cmd_pop;

  prat_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .proc_id_i,
    .address_i, .length_i, .page_offset_i, .inode_i, .dev_major_i,
    .dev_minor_i, .inode_generation_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  prat_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop),
    .cmd_i(cmd), .out_valid_o, .out_stall_i, .rsp_o(rsp)
  );

  assign status_o         = rsp.status;
  assign file_offset_o    = rsp.file_offset;
  assign hit_inode_o      = rsp.inode;
  assign hit_major_o      = rsp.major;
  assign hit_minor_o      = rsp.minor;
  assign hit_generation_o = rsp.generation;

endmodule

// ===== rtl/prat_front.sv =====
`timescale 1ns / 1ps
// classifies requests and queues them for the back end
module prat_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                req_type_i,
  input  logic [prat_pkg::PidW-1:0] proc_id_i,
  input  logic [63:0]               address_i,
  input  logic [63:0]               length_i,
  input  logic [63:0]               page_offset_i,
  input  logic [63:0]               inode_i,
  input  logic [31:0]               dev_major_i,
  input  logic [31:0]               dev_minor_i,
  input  logic [63:0]               inode_generation_i,
  output logic                      cmd_valid_o,
  input  logic                      cmd_pop_i,
  output prat_pkg::cmd_t            cmd_o
);

  prat_pkg::cmd_t q_mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  prat_pkg::cmd_t cmd_d;
  logic           push, pop;

  always_comb begin
    cmd_d.pid                = proc_id_i;
    cmd_d.address            = address_i;
    cmd_d.region.pid         = proc_id_i;
    cmd_d.region.start       = address_i;
    cmd_d.region.stop        = address_i + length_i;
    cmd_d.region.page_offset = page_offset_i;
    cmd_d.region.inode       = inode_i;
    cmd_d.region.major       = dev_major_i;
    cmd_d.region.minor       = dev_minor_i;
    cmd_d.region.generation  = inode_generation_i;
    unique case (req_type_i)
      prat_pkg::ReqInsert:    cmd_d.op = prat_pkg::OpInsert;
      prat_pkg::ReqRemove:    cmd_d.op = prat_pkg::OpRemove;
      prat_pkg::ReqTranslate: cmd_d.op = prat_pkg::OpTranslate;
      default:                cmd_d.op = prat_pkg::OpBad;
    endcase
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/prat_back.sv =====
`timescale 1ns / 1ps
// walks the region table one entry at a time, a read then a compare per entry
module prat_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  prat_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output prat_pkg::rsp_t rsp_o
);

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCheck,
    StDone
  } state_e;

  prat_pkg::region_t              table_q [prat_pkg::TableDepth];
  prat_pkg::region_t              rd_q;
  state_e                         state_q;
  prat_pkg::cmd_t                 cmd_q;
  logic [prat_pkg::CntW-1:0]      fill_q, scan_q, kept_q;
  logic                           out_valid_q;
  prat_pkg::rsp_t                 rsp_q;
  prat_pkg::rsp_t                 rsp_start;
  logic                           wr_en;
  logic [prat_pkg::IdxW-1:0]      wr_idx;
  prat_pkg::region_t              wr_data;
  logic                           hit;

  assign hit = (rd_q.pid == cmd_q.pid) && (cmd_q.address >= rd_q.start)
               && (cmd_q.address < rd_q.stop);

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = fill_q[prat_pkg::IdxW-1:0];
    wr_data = cmd_q.region;
    if (state_q == StIdle && cmd_valid_i && !out_valid_q
        && cmd_i.op == prat_pkg::OpInsert
        && fill_q != prat_pkg::CntW'(prat_pkg::TableDepth)) begin
      wr_en   = 1'b1;
      wr_data = cmd_i.region;
    end else if (state_q == StCheck && cmd_q.op == prat_pkg::OpRemove
                 && rd_q.pid != cmd_q.pid) begin
      // compaction: copy kept entry down
      wr_en   = 1'b1;
      wr_idx  = kept_q[prat_pkg::IdxW-1:0];
      wr_data = rd_q;
    end
  end

  // result a transaction starts with; a translate hit overwrites it later
  always_comb begin
    rsp_start = '0;
    if (cmd_i.op == prat_pkg::OpInsert) begin
      if (fill_q == prat_pkg::CntW'(prat_pkg::TableDepth)) begin
        rsp_start.status = prat_pkg::StatFull;
      end
    end else if (cmd_i.op != prat_pkg::OpRemove) begin
      rsp_start.status = prat_pkg::StatMiss;
    end
  end

  assign cmd_pop_o = (state_q == StIdle) && cmd_valid_i && !out_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[wr_idx] <= wr_data;
    end
    rd_q <= table_q[scan_q[prat_pkg::IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      scan_q      <= '0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (cmd_pop_o) begin
            scan_q <= '0;
            kept_q <= '0;
            rsp_q  <= rsp_start;
            unique case (cmd_i.op)
              prat_pkg::OpInsert: begin
                if (fill_q != prat_pkg::CntW'(prat_pkg::TableDepth)) begin
                  fill_q <= fill_q + 1'b1;
                end
                state_q <= StDone;
              end
              prat_pkg::OpRemove, prat_pkg::OpTranslate: begin
                state_q <= (fill_q == '0) ? StDone : StRead;
              end
              default: begin
                state_q <= StDone;
              end
            endcase
          end
        end
        StRead: state_q <= StCheck;
        StCheck: begin
          if (cmd_q.op == prat_pkg::OpTranslate && hit) begin
            rsp_q.status      <= prat_pkg::StatOk;
            rsp_q.file_offset <= cmd_q.address - rd_q.start + rd_q.page_offset;
            rsp_q.inode       <= rd_q.inode;
            rsp_q.major       <= rd_q.major;
            rsp_q.minor       <= rd_q.minor;
            rsp_q.generation  <= rd_q.generation;
            state_q           <= StDone;
          end else begin
            if (cmd_q.op == prat_pkg::OpRemove && rd_q.pid != cmd_q.pid) begin
              kept_q <= kept_q + 1'b1;
            end
            if (scan_q + 1'b1 == fill_q) begin
              if (cmd_q.op == prat_pkg::OpRemove) begin
                fill_q <= kept_q + {{(prat_pkg::CntW-1){1'b0}}, rd_q.pid != cmd_q.pid};
              end
              state_q <= StDone;
            end else begin
              scan_q  <= scan_q + 1'b1;
              state_q <= StRead;
            end
          end
        end
        StDone: begin
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== rtl/prat_checker.sv =====
`timescale 1ns / 1ps
module prat_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [63:0] file_offset_o,
  input logic [63:0] hit_inode_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == prat_pkg::StatOk || status_o == prat_pkg::StatMiss
                    || status_o == prat_pkg::StatFull)
    else $error("illegal status");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != prat_pkg::StatOk |-> file_offset_o == '0
                                                   && hit_inode_o == '0)
    else $error("non-hit result carries data");

endmodule

bind process_region_address_translator prat_checker u_prat_checker (.*);
